// File: design/hpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared constants, types and the key comparison for the heap priority queue.
// ----------------------------------------------------------------------------
package hpq_pkg;

   localparam int CAPACITY   = 64;
   localparam int KEY_BITS   = 32;
   localparam int TAG_BITS   = 16;
   localparam int ADDR_BITS  = $clog2(CAPACITY);
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);
   localparam int WIDE_BITS  = ADDR_BITS + 2;

   localparam int REQ_DATA_BITS = ((KEY_BITS + TAG_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((KEY_BITS + TAG_BITS + COUNT_BITS + 7) / 8) * 8;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef struct packed {
      logic [TAG_BITS-1:0]        tag;
      logic signed [KEY_BITS-1:0] key;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef struct packed {
      logic                  wr_en;
      logic [ADDR_BITS-1:0]  wr_addr;
      logic [ENTRY_BITS-1:0] wr_data;
      logic                  rd_en;
      logic [ADDR_BITS-1:0]  rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic                  valid;
      logic                  ok;
      entry_type             data;
      logic [COUNT_BITS-1:0] count;
   } result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_POP_LAST,
      ST_POP_MOVE,
      ST_DN_RD_L,
      ST_DN_RD_R,
      ST_DN_CMP,
      ST_RESP
   } state_type;

   // True when key a must be served strictly before key b.
   function automatic logic better(input logic signed [KEY_BITS-1:0] a,
                                   input logic signed [KEY_BITS-1:0] b,
                                   input logic min_first);
      better = min_first ? (a < b) : (a > b);
   endfunction

endpackage

// File: design/hpq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpq_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module hpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/hpq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpq_ctrl
// Sequencer that performs push with sift-up and pop with sift-down against the
// heap memory, carrying the moving entry in a register and filling the hole.
// ----------------------------------------------------------------------------
module hpq_ctrl import hpq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_op,
   input  entry_type             req_entry,
   output logic                  req_ready,
   input  logic                  min_first,
   output mem_req_type           mem,
   input  logic [ENTRY_BITS-1:0] mem_rd_data,
   input  logic                  rsp_free,
   output result_type            result
);

   state_type             state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [ADDR_BITS-1:0]  hole_ff, hole_in;
   entry_type             move_ff, move_in;
   entry_type             lchild_ff, lchild_in;
   entry_type             out_ff, out_in;
   logic                  ok_ff, ok_in;

   entry_type             rd_entry;
   logic                  is_empty;
   logic                  is_full;
   logic [ADDR_BITS-1:0]  hole_m1;
   logic [ADDR_BITS-1:0]  parent;
   logic                  up_swap;
   logic [WIDE_BITS-1:0]  left_w;
   logic [WIDE_BITS-1:0]  right_w;
   logic [WIDE_BITS-1:0]  count_w;
   logic                  left_valid;
   logic                  right_valid;
   logic                  pick_l;
   logic                  pick_r;
   logic signed [KEY_BITS-1:0] best_key;

   assign rd_entry    = entry_type'(mem_rd_data);
   assign is_empty    = (count_ff == '0);
   assign is_full     = (count_ff == COUNT_BITS'(CAPACITY));
   assign hole_m1     = hole_ff - ADDR_BITS'(1);
   assign parent      = {1'b0, hole_m1[ADDR_BITS-1:1]};
   assign up_swap     = better(move_ff.key, rd_entry.key, min_first);
   assign left_w      = {1'b0, hole_ff, 1'b1};
   assign right_w     = left_w + WIDE_BITS'(1);
   assign count_w     = WIDE_BITS'(count_ff);
   assign left_valid  = (left_w < count_w);
   assign right_valid = (right_w < count_w);
   assign pick_l      = better(lchild_ff.key, move_ff.key, min_first);
   assign best_key    = pick_l ? lchild_ff.key : move_ff.key;
   assign pick_r      = right_valid && better(rd_entry.key, best_key, min_first);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      hole_ff   <= hole_in;
      move_ff   <= move_in;
      lchild_ff <= lchild_in;
      out_ff    <= out_in;
      ok_ff     <= ok_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_POP) begin
                  state_in = is_empty ? ST_RESP : ST_POP_LAST;
               end else begin
                  state_in = is_full ? ST_RESP : ST_UP_RD;
               end
            end
         end
         ST_UP_RD:    state_in = (hole_ff == '0) ? ST_RESP : ST_UP_CMP;
         ST_UP_CMP:   state_in = up_swap ? ST_UP_RD : ST_RESP;
         ST_POP_LAST: state_in = ST_POP_MOVE;
         ST_POP_MOVE: state_in = is_empty ? ST_RESP : ST_DN_RD_L;
         ST_DN_RD_L:  state_in = left_valid ? ST_DN_RD_R : ST_RESP;
         ST_DN_RD_R:  state_in = ST_DN_CMP;
         ST_DN_CMP:   state_in = (pick_l || pick_r) ? ST_DN_RD_L : ST_RESP;
         ST_RESP:     state_in = rsp_free ? ST_IDLE : ST_RESP;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in  = count_ff;
      hole_in   = hole_ff;
      move_in   = move_ff;
      lchild_in = lchild_ff;
      out_in    = out_ff;
      ok_in     = ok_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               out_in = '0;
               if (req_op == OP_POP) begin
                  ok_in = !is_empty;
               end else begin
                  ok_in = !is_full;
                  if (!is_full) begin
                     hole_in  = count_ff[ADDR_BITS-1:0];
                     count_in = count_ff + COUNT_BITS'(1);
                     move_in  = req_entry;
                  end
               end
            end
         end
         ST_UP_CMP: begin
            if (up_swap) begin
               hole_in = parent;
            end
         end
         ST_POP_LAST: begin
            out_in   = rd_entry;
            count_in = count_ff - COUNT_BITS'(1);
         end
         ST_POP_MOVE: begin
            move_in = rd_entry;
            hole_in = '0;
         end
         ST_DN_RD_R: begin
            lchild_in = rd_entry;
         end
         ST_DN_CMP: begin
            if (pick_r) begin
               hole_in = right_w[ADDR_BITS-1:0];
            end else if (pick_l) begin
               hole_in = left_w[ADDR_BITS-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      mem          = '0;
      req_ready    = 1'b0;
      result       = '0;
      result.ok    = ok_ff;
      result.data  = out_ff;
      result.count = count_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            mem.rd_en   = req_valid && (req_op == OP_POP);
            mem.rd_addr = '0;
         end
         ST_UP_RD: begin
            if (hole_ff == '0) begin
               mem.wr_en   = 1'b1;
               mem.wr_addr = '0;
               mem.wr_data = move_ff;
            end else begin
               mem.rd_en   = 1'b1;
               mem.rd_addr = parent;
            end
         end
         ST_UP_CMP: begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = hole_ff;
            mem.wr_data = up_swap ? rd_entry : move_ff;
         end
         ST_POP_LAST: begin
            mem.rd_en   = 1'b1;
            mem.rd_addr = hole_m1 + ADDR_BITS'(count_ff[ADDR_BITS-1:0]) - hole_ff;
         end
         ST_DN_RD_L: begin
            if (left_valid) begin
               mem.rd_en   = 1'b1;
               mem.rd_addr = left_w[ADDR_BITS-1:0];
            end else begin
               mem.wr_en   = 1'b1;
               mem.wr_addr = hole_ff;
               mem.wr_data = move_ff;
            end
         end
         ST_DN_RD_R: begin
            mem.rd_en   = right_valid;
            mem.rd_addr = right_w[ADDR_BITS-1:0];
         end
         ST_DN_CMP: begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = hole_ff;
            if (pick_r) begin
               mem.wr_data = rd_entry;
            end else if (pick_l) begin
               mem.wr_data = lchild_ff;
            end else begin
               mem.wr_data = move_ff;
            end
         end
         ST_RESP: begin
            result.valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

// File: design/binary_heap_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// Fixed-capacity binary heap priority queue over one synchronous memory.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A push opens a hole at the bottom and
// moves it up level by level, reading the parent and then comparing and writing.
// A pop reads the root and the last entry, moves the last entry to the root and,
// unless the heap is now empty, sinks it level by level, reading the left and
// then the right child before comparing and writing. The single read port of
// the heap memory sets this order of steps. Refused operations (push when full,
// pop when empty) go straight to the response. The next request is taken
// while a response still waits.
module binary_heap_priority_queue import hpq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // tdata: item_key[31:0], item_tag[47:32]
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // tuser: op
   input  logic [0:0]               req_tuser,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // tdata: out_key[31:0], out_tag[47:32], entry_count[54:48], zero pad
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // tuser: ok
   output logic [0:0]               rsp_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // data: order_select
   input  logic [0:0]               csr_data,
   input  logic                     csr_valid,
   output logic                     csr_ready
);

   logic        order_select_ff, order_select_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff, rsp_in;

   entry_type   req_entry;
   mem_req_type mem;
   logic [ENTRY_BITS-1:0] mem_rd_data;
   result_type  result;
   logic        rsp_free;

   assign req_entry.key = req_tdata[KEY_BITS-1:0];
   assign req_entry.tag = req_tdata[KEY_BITS +: TAG_BITS];
   assign csr_ready     = 1'b1;
   assign rsp_free      = !rsp_valid_ff || rsp_tready;

   hpq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_op      (req_tuser[0]),
      .req_entry   (req_entry),
      .req_ready   (req_tready),
      .min_first   (order_select_ff),
      .mem         (mem),
      .mem_rd_data (mem_rd_data),
      .rsp_free    (rsp_free),
      .result      (result)
   );

   hpq_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (CAPACITY)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (mem.wr_en),
      .wr_addr (mem.wr_addr),
      .wr_data (mem.wr_data),
      .rd_en   (mem.rd_en),
      .rd_addr (mem.rd_addr),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      order_select_in = order_select_ff;
      if (csr_valid) begin
         order_select_in = csr_data[0];
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (result.valid && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_select_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         order_select_ff <= order_select_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.ok;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_ff.count, rsp_ff.data.tag, rsp_ff.data.key});

endmodule

// File: design/hpq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpq_checker
// Port-level checks for the heap priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module hpq_checker import hpq_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic [0:0]               rsp_tuser,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready
);

   logic [COUNT_BITS-1:0] rsp_count;

   assign rsp_count = rsp_tdata[KEY_BITS + TAG_BITS +: COUNT_BITS];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Response changed while stalled.");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[KEY_BITS + TAG_BITS - 1:0] == '0)
      else $error("Refused operation returned a nonzero entry.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_count <= COUNT_BITS'(CAPACITY))
      else $error("Entry count exceeds capacity.");

   a_refused_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |->
         rsp_count == '0 || rsp_count == COUNT_BITS'(CAPACITY))
      else $error("Operation refused while heap neither empty nor full.");

endmodule

bind binary_heap_priority_queue hpq_checker u_hpq_checker (.*);

// File: bench/binary_heap_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_tb
// Self-checking bench for the heap priority queue. Push and pop requests from a
// backlog are driven on the request stream. A behavioral heap predicts every
// response, including refused pushes and pops, and checks it field by field.
// The run covers a directed part and random fill and drain sweeps under both
// service orders and several backpressure profiles.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_tb;
   import hpq_pkg::*;

   typedef struct {
      logic                op;
      logic [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0] tag;
   } heap_request_type;

   typedef struct packed {
      logic                  ok;
      logic [KEY_BITS-1:0]   key;
      logic [TAG_BITS-1:0]   tag;
      logic [COUNT_BITS-1:0] count;
   } heap_response_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [0:0]               req_tuser = '0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [0:0]               rsp_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [0:0]               csr_data = '0;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;

   heap_request_type  request_backlog[$];
   heap_request_type  driven_request;
   heap_response_type expected_responses[$];
   heap_response_type wanted;

   entry_type heap_model[CAPACITY];
   int        heap_fill = 0;
   logic      model_min_first = 1'b0;

   int outstanding = 0;
   int mismatch_count = 0;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int gen_fill = 0;
   bit gen_filling = 1'b1;

   binary_heap_priority_queue i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic bit ranks_ahead(input logic signed [KEY_BITS-1:0] a,
                                      input logic signed [KEY_BITS-1:0] b);
      return (a != b) && ((a < b) == model_min_first);
   endfunction

   function automatic heap_response_type predict_heap_op(input heap_request_type rq);
      heap_response_type res;
      entry_type      held;
      int             pos;
      int             parent;
      int             left;
      int             pick;
      bit             settled;
      res = '0;
      settled = 1'b0;
      if (rq.op == OP_PUSH) begin
         if (heap_fill < CAPACITY) begin
            pos = heap_fill;
            heap_model[pos].key = rq.key;
            heap_model[pos].tag = rq.tag;
            heap_fill++;
            while (pos > 0 && !settled) begin
               parent = (pos - 1) / 2;
               if (ranks_ahead(heap_model[pos].key, heap_model[parent].key)) begin
                  held = heap_model[pos];
                  heap_model[pos] = heap_model[parent];
                  heap_model[parent] = held;
                  pos = parent;
               end else begin
                  settled = 1'b1;
               end
            end
            res.ok = 1'b1;
         end
      end else if (heap_fill > 0) begin
         res.ok = 1'b1;
         res.key = heap_model[0].key;
         res.tag = heap_model[0].tag;
         heap_fill--;
         heap_model[0] = heap_model[heap_fill];
         pos = 0;
         while (!settled) begin
            left = 2 * pos + 1;
            pick = pos;
            if (left < heap_fill && ranks_ahead(heap_model[left].key, heap_model[pick].key))
               pick = left;
            if (left + 1 < heap_fill
                && ranks_ahead(heap_model[left + 1].key, heap_model[pick].key))
               pick = left + 1;
            if (pick == pos) begin
               settled = 1'b1;
            end else begin
               held = heap_model[pos];
               heap_model[pos] = heap_model[pick];
               heap_model[pick] = held;
               pos = pick;
            end
         end
      end
      res.count = COUNT_BITS'(heap_fill);
      return res;
   endfunction

   task automatic note_mismatch(input string what, input logic [63:0] exp_val,
                                input logic [63:0] act_val);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: mismatch on %s: expected %0h, actual %0h",
                  $realtime, what, exp_val, act_val);
   endtask

   task automatic check_field(input string what, input logic [63:0] exp_val,
                              input logic [63:0] act_val);
      if (exp_val !== act_val)
         note_mismatch(what, exp_val, act_val);
   endtask

   // Request driver: each accepted transaction is run through the predictor.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_responses.push_back(predict_heap_op(driven_request));
         if (!req_tvalid || req_tready) begin
            if (request_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               driven_request = request_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= driven_request.op;
               req_tdata <= REQ_DATA_BITS'({driven_request.tag, driven_request.key});
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_responses.size() == 0) begin
               note_mismatch("unexpected response", '0, 64'(rsp_tdata));
            end else begin
               wanted = expected_responses.pop_front();
               check_field("ok", wanted.ok, rsp_tuser[0]);
               check_field("out_key", wanted.key, rsp_tdata[KEY_BITS-1:0]);
               check_field("out_tag", wanted.tag, rsp_tdata[KEY_BITS +: TAG_BITS]);
               check_field("entry_count", wanted.count,
                           rsp_tdata[KEY_BITS+TAG_BITS +: COUNT_BITS]);
               outstanding--;
            end
         end
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   task automatic queue_request(input logic op, input logic [KEY_BITS-1:0] key,
                                input logic [TAG_BITS-1:0] tag);
      heap_request_type rq;
      rq.op = op;
      rq.key = key;
      rq.tag = tag;
      request_backlog.push_back(rq);
      outstanding++;
   endtask

   function automatic logic [KEY_BITS-1:0] random_key();
      int pick;
      pick = $urandom_range(99);
      if (pick < 45)
         return $urandom;
      if (pick < 85)
         return KEY_BITS'(int'($urandom_range(6)) - 3);
      case ($urandom_range(3))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         default: return 32'hffff_ffff;
      endcase
   endfunction

   // Random sweeps that fill the heap past capacity and drain it past empty.
   task automatic queue_random(input int n);
      int   push_pct;
      logic op_sel;
      for (int k = 0; k < n; k++) begin
         if (gen_filling && gen_fill == CAPACITY && $urandom_range(2) == 0)
            gen_filling = 1'b0;
         else if (!gen_filling && gen_fill == 0 && $urandom_range(2) == 0)
            gen_filling = 1'b1;
         push_pct = gen_filling ? 85 : 15;
         op_sel = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
         if (op_sel == OP_PUSH && gen_fill < CAPACITY)
            gen_fill++;
         else if (op_sel == OP_POP && gen_fill > 0)
            gen_fill--;
         queue_request(op_sel, random_key(), TAG_BITS'($urandom_range(16'hffff)));
      end
   endtask

   task automatic wait_idle();
      while (outstanding != 0)
         @(posedge clock);
   endtask

   task automatic write_order(input logic min_first);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= min_first;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      model_min_first = min_first;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 19;
      receiver_idle_pct = 69;
      write_order(1'b0);

      // Directed: empty pop, extreme keys and tags, equal keys with distinct
      // tags, and a left-child tie on the way down.
      queue_request(OP_POP, 32'hffff_ffff, 16'hffff);
      queue_request(OP_PUSH, 32'h7fff_ffff, 16'hffff);
      queue_request(OP_PUSH, 32'h8000_0000, 16'h0000);
      queue_request(OP_PUSH, 32'h0000_0000, 16'h1234);
      queue_request(OP_PUSH, 32'hffff_ffff, 16'habcd);
      for (int k = 1; k <= 4; k++)
         queue_request(OP_PUSH, 32'd5, TAG_BITS'(k));
      for (int k = 0; k < 9; k++)
         queue_request(OP_POP, 32'h0, 16'h0);
      queue_request(OP_PUSH, 32'd9, 16'h0010);
      queue_request(OP_PUSH, 32'd3, 16'h0011);
      queue_request(OP_PUSH, 32'd3, 16'h0012);
      for (int k = 0; k < 4; k++)
         queue_request(OP_POP, 32'h5555_aaaa, 16'h5a5a);
      wait_idle();

      write_order(1'b1);
      queue_random(225);
      wait_idle();

      sender_idle_pct = 69;
      receiver_idle_pct = 19;
      write_order(1'b0);
      queue_random(225);
      wait_idle();

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      write_order(1'b1);
      queue_random(225);
      wait_idle();

      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && expected_responses.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: sim.f
design/hpq_pkg.sv
design/hpq_ram.sv
design/hpq_ctrl.sv
design/binary_heap_priority_queue.sv
design/hpq_checker.sv
bench/binary_heap_priority_queue_tb.sv
